// ===== src/uf2bc_pkg.sv =====
package uf2bc_pkg;

    // Image and block geometry
    localparam int CRC_SPAN_BYTES      = 252;
    localparam int BLOCK_PAYLOAD_BYTES = 256;
    localparam int WORDS_PER_BLOCK     = BLOCK_PAYLOAD_BYTES / 4;
    localparam int PATCH_WORD          = 63;
    localparam int DATA_AREA_BYTES     = 476;
    localparam int PAD_WORDS           = (DATA_AREA_BYTES - BLOCK_PAYLOAD_BYTES) / 4;
    localparam int ADDR_SHIFT          = $clog2(BLOCK_PAYLOAD_BYTES);
    localparam int IDX_W               = $clog2(WORDS_PER_BLOCK);
    localparam int BLK_W               = 17;
    localparam int PADDR_W             = 4;

    // Fixed words
    localparam logic [31:0] CRC_POLY       = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
    localparam logic [31:0] UF2_SIG_HEAD0  = 32'h0A324655;
    localparam logic [31:0] UF2_SIG_HEAD1  = 32'h9E5D5157;
    localparam logic [31:0] UF2_SIG_TAIL   = 32'h0AB16F30;
    localparam logic [31:0] FLAG_FAMILY    = 32'h00002000;
    localparam logic [31:0] BLOCK_DATA_LEN = 32'(BLOCK_PAYLOAD_BYTES);
    localparam logic [31:0] RST_BASE       = 32'h10000000;
    localparam logic [31:0] RST_FAMILY     = 32'hE48BFF56;

    // Output sequence positions within one item
    localparam logic [5:0] SEQ_MAGIC0    = 6'd0;
    localparam logic [5:0] SEQ_MAGIC1    = 6'd1;
    localparam logic [5:0] SEQ_FLAGS     = 6'd2;
    localparam logic [5:0] SEQ_ADDR      = 6'd3;
    localparam logic [5:0] SEQ_SIZE      = 6'd4;
    localparam logic [5:0] SEQ_BLKNUM    = 6'd5;
    localparam logic [5:0] SEQ_BLKCNT    = 6'd6;
    localparam logic [5:0] SEQ_FAMILY    = 6'd7;
    localparam logic [5:0] SEQ_DATA      = 6'd0;
    localparam logic [5:0] SEQ_TRL_MAGIC = 6'(PAD_WORDS + 1);

    // Register indexes
    localparam logic [1:0] REG_RAW    = 2'd0;
    localparam logic [1:0] REG_TOTAL  = 2'd1;
    localparam logic [1:0] REG_BASE   = 2'd2;
    localparam logic [1:0] REG_FAMILY = 2'd3;

    typedef struct packed {
        logic             raw;
        logic [BLK_W-1:0] total;
        logic [31:0]      base;
        logic [31:0]      family;
    } t_cfg;

    typedef struct packed {
        logic [31:0]      word;
        logic             hdr;
        logic             trl;
        logic [BLK_W-1:0] blk;
    } t_job;

    // Effect of a single bit at position p after nbits shift steps
    function automatic logic [31:0] crc_col(int p, int nbits);
        logic [31:0] v;
        v = 32'd1 << p;
        for (int k = 0; k < 32; k++) begin
            if (k < nbits) begin
                v = v[31] ? ((v << 1) ^ CRC_POLY) : (v << 1);
            end
        end
        return v;
    endfunction

    // nb bytes of MSB-first CRC, d holds the first byte in its top bits
    function automatic logic [31:0] crc_bytes(logic [31:0] crc, logic [31:0] d, int nb);
        logic [31:0] x;
        logic [31:0] r;
        logic [31:0] mask;
        int          nbits;
        nbits = 8 * nb;
        mask  = ~(32'hFFFFFFFF >> nbits);
        x     = crc ^ (d & mask);
        r     = x << nbits;
        for (int p = 0; p < 32; p++) begin
            if (mask[p] && x[p]) begin
                r = r ^ crc_col(p, nbits);
            end
        end
        return r;
    endfunction

    // Word update over the leading nbytes bytes of a little-endian word
    function automatic logic [31:0] crc_update(logic [31:0] crc, logic [31:0] w,
                                               logic [2:0] nbytes);
        logic [31:0] d;
        d = {w[7:0], w[15:8], w[23:16], w[31:24]};
        case (nbytes)
            3'd1:    return crc_bytes(crc, d, 1);
            3'd2:    return crc_bytes(crc, d, 2);
            3'd3:    return crc_bytes(crc, d, 3);
            3'd4:    return crc_bytes(crc, d, 4);
            default: return crc;
        endcase
    endfunction

endpackage

// ===== src/uf2bc_cfg.sv =====
module uf2bc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [uf2bc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output uf2bc_pkg::t_cfg              o_cfg
);

    uf2bc_pkg::t_cfg r_cfg;
    logic [1:0]      w_index;
    logic            w_wr;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_wr    = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw    <= 1'b0;
            r_cfg.total  <= '0;
            r_cfg.base   <= uf2bc_pkg::RST_BASE;
            r_cfg.family <= uf2bc_pkg::RST_FAMILY;
        end else if (w_wr) begin
            case (w_index)
                uf2bc_pkg::REG_RAW:    r_cfg.raw    <= pwdata[0];
                uf2bc_pkg::REG_TOTAL:  r_cfg.total  <= pwdata[uf2bc_pkg::BLK_W-1:0];
                uf2bc_pkg::REG_BASE:   r_cfg.base   <= pwdata;
                uf2bc_pkg::REG_FAMILY: r_cfg.family <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_index)
            uf2bc_pkg::REG_RAW:    prdata = {31'd0, r_cfg.raw};
            uf2bc_pkg::REG_TOTAL:  prdata = 32'(r_cfg.total);
            uf2bc_pkg::REG_BASE:   prdata = r_cfg.base;
            uf2bc_pkg::REG_FAMILY: prdata = r_cfg.family;
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== src/uf2bc_crc.sv =====
module uf2bc_crc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [31:0]     i_image_word,
    input  logic            i_raw,
    output uf2bc_pkg::t_job o_job
);

    localparam logic [8:0] SPAN = 9'(uf2bc_pkg::CRC_SPAN_BYTES);
    localparam logic [uf2bc_pkg::IDX_W-1:0] PATCH_IDX = uf2bc_pkg::IDX_W'(uf2bc_pkg::PATCH_WORD);
    localparam logic [uf2bc_pkg::IDX_W-1:0] LAST_IDX  =
        uf2bc_pkg::IDX_W'(uf2bc_pkg::WORDS_PER_BLOCK - 1);

    logic [31:0]                  r_crc, n_crc;
    logic [uf2bc_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [uf2bc_pkg::BLK_W-1:0]  r_blk, n_blk;
    logic                         r_done, n_done;
    logic [8:0]                   w_off;
    logic [8:0]                   w_diff;
    logic [2:0]                   w_nbytes;
    logic                         w_patch;
    logic                         w_end;

    // Bytes of this word that fall inside the CRC span
    assign w_off  = {1'b0, r_idx, 2'b00};
    assign w_diff = SPAN - w_off;
    always_comb begin
        if (w_off + 9'd4 <= SPAN) begin
            w_nbytes = 3'd4;
        end else if (w_off >= SPAN) begin
            w_nbytes = 3'd0;
        end else begin
            w_nbytes = w_diff[2:0];
        end
    end

    assign w_patch = !r_done && (r_idx == PATCH_IDX);
    assign w_end   = (r_idx == LAST_IDX);

    // CRC, position and block number for the next word
    always_comb begin
        n_crc  = r_crc;
        n_idx  = r_idx + 1'b1;
        n_blk  = r_blk;
        n_done = r_done;
        if (!r_done && !w_patch) begin
            n_crc = uf2bc_pkg::crc_update(r_crc, i_image_word, w_nbytes);
        end
        if (w_end) begin
            n_idx  = '0;
            n_blk  = r_blk + 1'b1;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= uf2bc_pkg::CRC_INIT;
            r_idx  <= '0;
            r_blk  <= '0;
            r_done <= 1'b0;
        end else if (i_take) begin
            r_crc  <= n_crc;
            r_idx  <= n_idx;
            r_blk  <= n_blk;
            r_done <= n_done;
        end
    end

    // Job for the emitter
    assign o_job.word = w_patch ? r_crc : i_image_word;
    assign o_job.hdr  = !i_raw && (r_idx == '0);
    assign o_job.trl  = !i_raw && w_end;
    assign o_job.blk  = r_blk;

endmodule

// ===== src/uf2bc_emit.sv =====
module uf2bc_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  uf2bc_pkg::t_job i_job,
    input  uf2bc_pkg::t_cfg i_cfg,
    input  logic            i_out_stall,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output logic [31:0]     o_out_word,
    output logic            o_run_last
);

    uf2bc_pkg::t_job r_job;
    logic            r_job_vld;
    logic [5:0]      r_seq;
    logic            r_out_vld;
    logic [31:0]     r_out_word;
    logic            r_out_last;
    logic            w_out_free;
    logic            w_load;
    logic [31:0]     w_word;
    logic            w_last;
    logic [31:0]     w_addr;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_load     = r_job_vld && w_out_free;
    assign o_in_stall = r_job_vld && !(w_out_free && w_last);
    assign w_addr     = i_cfg.base + (32'(r_job.blk) << uf2bc_pkg::ADDR_SHIFT);

    // Word selection for the current sequence position
    always_comb begin
        w_word = r_job.word;
        w_last = 1'b1;
        if (r_job.hdr) begin
            w_last = 1'b0;
            case (r_seq)
                uf2bc_pkg::SEQ_MAGIC0: w_word = uf2bc_pkg::UF2_SIG_HEAD0;
                uf2bc_pkg::SEQ_MAGIC1: w_word = uf2bc_pkg::UF2_SIG_HEAD1;
                uf2bc_pkg::SEQ_FLAGS:  w_word = uf2bc_pkg::FLAG_FAMILY;
                uf2bc_pkg::SEQ_ADDR:   w_word = w_addr;
                uf2bc_pkg::SEQ_SIZE:   w_word = uf2bc_pkg::BLOCK_DATA_LEN;
                uf2bc_pkg::SEQ_BLKNUM: w_word = 32'(r_job.blk);
                uf2bc_pkg::SEQ_BLKCNT: w_word = 32'(i_cfg.total);
                uf2bc_pkg::SEQ_FAMILY: w_word = i_cfg.family;
                default: begin
                    w_word = r_job.word;
                    w_last = 1'b1;
                end
            endcase
        end else if (r_job.trl) begin
            if (r_seq == uf2bc_pkg::SEQ_DATA) begin
                w_word = r_job.word;
                w_last = 1'b0;
            end else if (r_seq == uf2bc_pkg::SEQ_TRL_MAGIC) begin
                w_word = uf2bc_pkg::UF2_SIG_TAIL;
                w_last = 1'b1;
            end else begin
                w_word = '0;
                w_last = 1'b0;
            end
        end
    end

    // Job slot and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
            r_seq     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_take) begin
                r_job_vld <= 1'b1;
                r_seq     <= '0;
            end else if (w_load && w_last) begin
                r_job_vld <= 1'b0;
            end else if (w_load) begin
                r_seq <= r_seq + 1'b1;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_job <= i_job;
        end
        if (w_load) begin
            r_out_word <= w_word;
            r_out_last <= w_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;
    assign o_run_last  = r_out_last;

endmodule

// ===== src/uf2_framer_with_boot_crc.sv =====
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------
// input    | in        | i_in_valid/o_in_stall | i_image_word
// output   | out       | o_out_valid/i_out_stall | o_out_word, o_run_last
// config   | in        | APB psel/penable      | paddr, pwdata, prdata
//
// An input word is taken in the cycle its job slot frees; it yields 1 output word
// (raw mode or mid-block), 9 (block start) or 57 (block end), one per unstalled cycle
// through the output register, so a full UF2 block of 64 words yields 128 output words.
// Reset is synchronous and clears counters, CRC, valids and the config registers.
// An output stall holds the output register and, once the job slot is busy,
// stalls the input.
module uf2_framer_with_boot_crc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_image_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [31:0]                   o_out_word,
    output logic                          o_run_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uf2bc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    uf2bc_pkg::t_cfg w_cfg;
    uf2bc_pkg::t_job w_job;
    logic            w_take;

    // Input transfer
    assign w_take = i_in_valid && !o_in_stall;

    uf2bc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    uf2bc_crc u_crc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_image_word (i_image_word),
        .i_raw        (w_cfg.raw),
        .o_job        (w_job)
    );

    uf2bc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_job       (w_job),
        .i_cfg       (w_cfg),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== src/uf2bc_checker.sv =====
module uf2bc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_out_word,
    input logic        o_run_last
);

    // Reset empties the output register and frees the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall not cleared by reset");

    // A stalled output holds its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word)
            && $stable(o_run_last))
        else $error("stalled output changed");

    // Input is only held off while a job is driving the output register
    a_stall_feeds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> o_out_valid)
        else $error("input stalled with no output produced");

    // An accepted word reaches the output through the job slot and the output register
    a_take_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##2 o_out_valid)
        else $error("accepted word produced no output");

endmodule

bind uf2_framer_with_boot_crc uf2bc_checker u_uf2bc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .o_run_last  (o_run_last)
);

// ===== bench/uf2_framer_with_boot_crc_tb.sv =====
`timescale 1ns / 100ps

module uf2_framer_with_boot_crc_tb;

    // One expected output transfer
    typedef struct {
        logic [31:0] word;
        logic        last;
    } t_frame_beat;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_in_valid   = 1'b0;
    logic                           o_in_stall;
    logic [31:0]                    i_image_word = '0;
    logic                           o_out_valid;
    logic                           i_out_stall  = 1'b0;
    logic [31:0]                    o_out_word;
    logic                           o_run_last;
    logic                           psel         = 1'b0;
    logic                           penable      = 1'b0;
    logic                           pwrite       = 1'b0;
    logic [uf2bc_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [31:0]                    pwdata       = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // Shadow of the register file
    logic                           cfg_raw;
    logic [uf2bc_pkg::BLK_W-1:0]    cfg_total;
    logic [31:0]                    cfg_base;
    logic [31:0]                    cfg_family;

    // Framer state as the bench sees it
    logic [31:0]                    image_crc;
    logic [uf2bc_pkg::IDX_W-1:0]    slot_idx;
    logic [uf2bc_pkg::BLK_W-1:0]    blk_count;
    logic                           crc_sealed;

    t_frame_beat                    expected_words[$];
    int                             error_count = 0;
    int                             beat_count  = 0;
    logic                           idle_on     = 1'b1;

    uf2_framer_with_boot_crc u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_image_word (i_image_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word),
        .o_run_last   (o_run_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t beat %0d: %s", $realtime, beat_count, msg);
        error_count++;
    endtask

    // MSB-first CRC-32/MPEG-2, one byte
    function automatic logic [31:0] crc_mpeg2_byte(input logic [31:0] crc,
                                                   input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ uf2bc_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void push_beat(input logic [31:0] w, input logic last);
        t_frame_beat b;
        b.word = w;
        b.last = last;
        expected_words.push_back(b);
    endfunction

    // Expected output words for one accepted image word
    function automatic void predict_framed_words(input logic [31:0] w_in);
        logic [31:0]                 w;
        logic [uf2bc_pkg::IDX_W-1:0] idx;
        logic                        has_trailer;
        w   = w_in;
        idx = slot_idx;
        has_trailer = !cfg_raw && (int'(idx) == uf2bc_pkg::WORDS_PER_BLOCK - 1);

        // CRC over the leading bytes of the image, patch into word 63
        if (!crc_sealed) begin
            if (int'(idx) == uf2bc_pkg::PATCH_WORD) begin
                w = image_crc;
            end else begin
                for (int k = 0; k < 4; k++) begin
                    if (int'(idx) * 4 + k < uf2bc_pkg::CRC_SPAN_BYTES)
                        image_crc = crc_mpeg2_byte(image_crc, w_in[8*k +: 8]);
                end
            end
        end

        if (!cfg_raw && idx == '0) begin
            push_beat(uf2bc_pkg::UF2_SIG_HEAD0, 1'b0);
            push_beat(uf2bc_pkg::UF2_SIG_HEAD1, 1'b0);
            push_beat(uf2bc_pkg::FLAG_FAMILY, 1'b0);
            push_beat(cfg_base + (32'(blk_count) << uf2bc_pkg::ADDR_SHIFT), 1'b0);
            push_beat(uf2bc_pkg::BLOCK_DATA_LEN, 1'b0);
            push_beat(32'(blk_count), 1'b0);
            push_beat(32'(cfg_total), 1'b0);
            push_beat(cfg_family, 1'b0);
        end

        push_beat(w, !has_trailer);

        if (has_trailer) begin
            for (int k = 0; k < uf2bc_pkg::PAD_WORDS; k++) push_beat(32'h0, 1'b0);
            push_beat(uf2bc_pkg::UF2_SIG_TAIL, 1'b1);
        end

        if (int'(idx) == uf2bc_pkg::WORDS_PER_BLOCK - 1) begin
            slot_idx   = '0;
            blk_count  = blk_count + 1'b1;
            crc_sealed = 1'b1;
        end else begin
            slot_idx = idx + 1'b1;
        end
    endfunction

    // Compare one output transfer with the oldest expectation
    task automatic check_out_word;
        t_frame_beat exp_beat;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h last %b", o_out_word, o_run_last));
            return;
        end
        exp_beat = expected_words.pop_front();
        if (o_out_word !== exp_beat.word)
            report_mismatch($sformatf("word %h, expected %h", o_out_word, exp_beat.word));
        if (o_run_last !== exp_beat.last)
            report_mismatch($sformatf("run_last %b, expected %b", o_run_last, exp_beat.last));
        beat_count++;
    endtask

    // Output side: check transfers, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_out_word();
        i_out_stall <= idle_on && ($urandom_range(0, 99) < 9);
    end

    // Register write: setup then access phase, then the bus returns to idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            uf2bc_pkg::REG_RAW:    cfg_raw    = value[0];
            uf2bc_pkg::REG_TOTAL:  cfg_total  = value[uf2bc_pkg::BLK_W-1:0];
            uf2bc_pkg::REG_BASE:   cfg_base   = value;
            uf2bc_pkg::REG_FAMILY: cfg_family = value;
            default: ;
        endcase
    endtask

    // One input transfer, with random idle cycles ahead of it
    task automatic send_word(input logic [31:0] w);
        while (idle_on && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_image_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        predict_framed_words(w);
    endtask

    // Stop sending and let every expected word come out
    task automatic wait_drained;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word;
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Field extremes and walking bits at the head of block 0, reset config
    task automatic test_directed_extremes;
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        send_word(32'h8000_0001);
        send_word(32'h7FFF_FFFE);
        for (int k = 0; k < 14; k++) send_word(32'h1 << (k * 2 + 3));
    endtask

    // Rest of block 0: CRC patch into word 63 and trailer
    task automatic test_first_block_crc;
        while (slot_idx != '0) send_word(pick_word());
    endtask

    // Raw mode from the start of block 1, then back to framing mid-block
    task automatic test_raw_mode_switch;
        wait_drained();
        write_reg(uf2bc_pkg::REG_RAW, 32'h1);
        for (int k = 0; k < 12; k++) send_word(pick_word());
        wait_drained();
        write_reg(uf2bc_pkg::REG_RAW, 32'h0);
        for (int k = 0; k < 8; k++) send_word(pick_word());
    endtask

    // Sender holds off until every expected word is out
    task automatic test_pause_until_drained;
        for (int k = 0; k < 15; k++) send_word(pick_word());
        wait_drained();
        for (int k = 0; k < 15; k++) send_word(pick_word());
    endtask

    // A full block's worth with neither side idling
    task automatic test_no_idle_stretch;
        idle_on = 1'b0;
        for (int k = 0; k < uf2bc_pkg::WORDS_PER_BLOCK; k++) send_word(pick_word());
        idle_on = 1'b1;
    endtask

    // Phases of random words, new register values between phases
    task automatic test_random_stream;
        logic [31:0] total_v;
        logic [31:0] base_v;
        logic [31:0] family_v;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    total_v  = 32'd65536;
                    base_v   = 32'hFFFF_FFFF;
                    family_v = 32'hFFFF_FFFF;
                end
                1: begin
                    total_v  = 32'd0;
                    base_v   = 32'h0;
                    family_v = 32'h0;
                end
                2: begin
                    total_v  = $urandom_range(0, 65536);
                    base_v   = 32'hFFFF_FF00;
                    family_v = $urandom;
                end
                default: begin
                    total_v  = $urandom_range(0, 65536);
                    base_v   = $urandom;
                    family_v = $urandom;
                end
            endcase
            wait_drained();
            write_reg(uf2bc_pkg::REG_RAW, (phase == 3) ? 32'h1 : 32'h0);
            write_reg(uf2bc_pkg::REG_TOTAL, total_v);
            write_reg(uf2bc_pkg::REG_BASE, base_v);
            write_reg(uf2bc_pkg::REG_FAMILY, family_v);
            for (int k = 0; k < 17; k++) send_word(pick_word());
        end
    endtask

    initial begin
        // Shadow state matches the block's reset
        cfg_raw    = 1'b0;
        cfg_total  = '0;
        cfg_base   = uf2bc_pkg::RST_BASE;
        cfg_family = uf2bc_pkg::RST_FAMILY;
        image_crc  = uf2bc_pkg::CRC_INIT;
        slot_idx   = '0;
        blk_count  = '0;
        crc_sealed = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_first_block_crc();
        test_raw_mode_switch();
        test_pause_until_drained();
        test_no_idle_stretch();
        test_random_stream();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/uf2bc_pkg.sv
src/uf2bc_cfg.sv
src/uf2bc_crc.sv
src/uf2bc_emit.sv
src/uf2_framer_with_boot_crc.sv
src/uf2bc_checker.sv
bench/uf2_framer_with_boot_crc_tb.sv
